FILE: src/rlg_pkg.sv
// Shared types, constants and the level scaling table for the RGB gradient block.
// No dependencies; the RTL files refer to it by scoped names and the testbench imports it.
`timescale 1ns / 1ps

package rlg_pkg;

    localparam int INDEX_WIDTH_DEF = 16;
    localparam int STEP_WIDTH      = 16;
    localparam int CHAN_WIDTH      = 8;
    localparam int LEVEL_WIDTH     = 10;
    localparam int NUM_CHAN        = 3;
    localparam int QUOT_BITS       = LEVEL_WIDTH;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 16;
    localparam int LEVEL_MAX       = 1000;
    localparam int COUNT_RESET     = 2;

    localparam int CHAN_RED   = 0;
    localparam int CHAN_GREEN = 1;
    localparam int CHAN_BLUE  = 2;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_START_RED   = 3'd0,
        REG_START_GREEN = 3'd1,
        REG_START_BLUE  = 3'd2,
        REG_END_RED     = 3'd3,
        REG_END_GREEN   = 3'd4,
        REG_END_BLUE    = 3'd5,
        REG_STEP_COUNT  = 3'd6
    } reg_index_t;

    typedef logic [LEVEL_WIDTH-1:0] level_t;

    // Start and end colors, already scaled to 0..1000.
    typedef struct packed {
        logic [NUM_CHAN-1:0][LEVEL_WIDTH-1:0] start_lvl;
        logic [NUM_CHAN-1:0][LEVEL_WIDTH-1:0] end_lvl;
    } color_cfg_t;

    typedef logic [(1 << CHAN_WIDTH)-1:0][LEVEL_WIDTH-1:0] scale_lut_t;

    // 8-bit channel to 0..1000, round to nearest: (2000c + 255) / 510.
    function automatic scale_lut_t build_scale_lut();
        scale_lut_t lut;
        for (int c = 0; c < (1 << CHAN_WIDTH); c++) begin
            lut[c] = LEVEL_WIDTH'((2000 * c + 255) / 510);
        end
        return lut;
    endfunction

    localparam scale_lut_t SCALE_LUT = build_scale_lut();

endpackage

FILE: src/rgb_linear_gradient_step.sv
// Top level of the RGB linear gradient block: config registers, front stages, divider, output.
// Depends on rlg_pkg, rlg_cfg_regs, rlg_front and rlg_div_pipe.
`timescale 1ns / 1ps

// Usage
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): cfg_ready is always high.
//   Index 0..5 write start/end red, green, blue (low 8 bits), index 6 the step
//   count (low INDEX_WIDTH bits); other indexes are dropped. Write only while idle.
//   Input channel (s_valid/s_ready, s_step_index): one step index per item.
//   Result channel (m_valid/m_ready, m_red, m_green, m_blue, m_index_error): one
//   result item per input item, in order. Colors are on a 0..1000 scale; an index
//   at or above the step count gives m_index_error = 1 and zero colors.
// Pipeline and throughput
//   Registered stages from input accept to m_valid: range check, multiply-add, ten divider
//   stages (one quotient bit each, set by the 10-bit result width), output register.
//   One item per cycle sustained while the output is not stalled; the whole pipeline advances together.
// Reset
//   aresetn (synchronous, active low) clears all valid bits and loads the register
//   reset values: start black, end white, step count 2.
// Stall
//   While m_valid is high and m_ready low, every stage holds and s_ready drops;
//   no item is lost or repeated. s_ready is high whenever the output is empty or taken.

module rgb_linear_gradient_step #(
    parameter int INDEX_WIDTH = rlg_pkg::INDEX_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rlg_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [rlg_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    // input items
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rlg_pkg::STEP_WIDTH-1:0]      s_step_index,
    // result items
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rlg_pkg::LEVEL_WIDTH-1:0]     m_red,
    output logic [rlg_pkg::LEVEL_WIDTH-1:0]     m_green,
    output logic [rlg_pkg::LEVEL_WIDTH-1:0]     m_blue,
    output logic                                m_index_error
);

    localparam int NUM_WIDTH = INDEX_WIDTH + rlg_pkg::QUOT_BITS;
    localparam int NC        = rlg_pkg::NUM_CHAN;
    localparam int QB        = rlg_pkg::QUOT_BITS;

    rlg_pkg::color_cfg_t    colors;
    logic [INDEX_WIDTH-1:0] step_count;

    logic                         adv;
    logic                         num_valid, num_err;
    logic [NC-1:0][NUM_WIDTH-1:0] num;
    logic [INDEX_WIDTH-1:0]       span;
    logic                         div_valid, div_err;
    logic [NC-1:0][QB-1:0]        div_quot;

    logic                   m_valid_reg;
    logic [NC-1:0][QB-1:0]  m_color_reg, m_color_next;
    logic                   m_err_reg;

    // Global advance: the pipeline moves unless a finished item is waiting.
    assign adv       = ~m_valid_reg | m_ready;
    assign s_ready   = adv;
    assign cfg_ready = 1'b1;

    rlg_cfg_regs #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .colors     (colors),
        .step_count (step_count)
    );

    rlg_front #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (s_valid),
        .in_index   (INDEX_WIDTH'(s_step_index)),
        .colors     (colors),
        .step_count (step_count),
        .out_valid  (num_valid),
        .out_num    (num),
        .out_span   (span),
        .out_err    (num_err)
    );

    rlg_div_pipe #(
        .INDEX_WIDTH (INDEX_WIDTH)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (num_valid),
        .in_num    (num),
        .in_span   (span),
        .in_err    (num_err),
        .out_valid (div_valid),
        .out_quot  (div_quot),
        .out_err   (div_err)
    );

    // Out-of-range items carry whatever the divider produced; zero them here.
    always_comb begin
        for (int ch = 0; ch < NC; ch++) begin
            m_color_next[ch] = div_err ? '0 : div_quot[ch];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_color_reg <= m_color_next;
            m_err_reg   <= div_err;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_red         = m_color_reg[rlg_pkg::CHAN_RED];
    assign m_green       = m_color_reg[rlg_pkg::CHAN_GREEN];
    assign m_blue        = m_color_reg[rlg_pkg::CHAN_BLUE];
    assign m_index_error = m_err_reg;

endmodule

FILE: src/rlg_cfg_regs.sv
// Configuration registers: colors stored pre-scaled to 0..1000, plus the step count.
// Depends on rlg_pkg.
`timescale 1ns / 1ps

module rlg_cfg_regs #(
    parameter int INDEX_WIDTH = rlg_pkg::INDEX_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    input  logic [rlg_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  logic [rlg_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    output rlg_pkg::color_cfg_t                  colors,
    output logic [INDEX_WIDTH-1:0]               step_count
);

    rlg_pkg::color_cfg_t    colors_reg, colors_next;
    logic [INDEX_WIDTH-1:0] count_reg, count_next;
    rlg_pkg::level_t        wr_level;

    assign wr_level = rlg_pkg::SCALE_LUT[cfg_data[rlg_pkg::CHAN_WIDTH-1:0]];

    always_comb begin
        colors_next = colors_reg;
        count_next  = count_reg;
        if (cfg_valid) begin
            unique case (rlg_pkg::reg_index_t'(cfg_index))
                rlg_pkg::REG_START_RED:   colors_next.start_lvl[rlg_pkg::CHAN_RED]   = wr_level;
                rlg_pkg::REG_START_GREEN: colors_next.start_lvl[rlg_pkg::CHAN_GREEN] = wr_level;
                rlg_pkg::REG_START_BLUE:  colors_next.start_lvl[rlg_pkg::CHAN_BLUE]  = wr_level;
                rlg_pkg::REG_END_RED:     colors_next.end_lvl[rlg_pkg::CHAN_RED]     = wr_level;
                rlg_pkg::REG_END_GREEN:   colors_next.end_lvl[rlg_pkg::CHAN_GREEN]   = wr_level;
                rlg_pkg::REG_END_BLUE:    colors_next.end_lvl[rlg_pkg::CHAN_BLUE]    = wr_level;
                rlg_pkg::REG_STEP_COUNT:  count_next = INDEX_WIDTH'(cfg_data);
                default: ;  // index beyond the list: ignored
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int ch = 0; ch < rlg_pkg::NUM_CHAN; ch++) begin
                colors_reg.start_lvl[ch] <= rlg_pkg::SCALE_LUT[0];
                colors_reg.end_lvl[ch]   <= rlg_pkg::SCALE_LUT[(1 << rlg_pkg::CHAN_WIDTH) - 1];
            end
            count_reg <= INDEX_WIDTH'(rlg_pkg::COUNT_RESET);
        end else begin
            colors_reg <= colors_next;
            count_reg  <= count_next;
        end
    end

    assign colors     = colors_reg;
    assign step_count = count_reg;

endmodule

FILE: src/rlg_front.sv
// Front of the pipeline: range check and span (stage A), weighted sum numerators (stage B).
// Depends on rlg_pkg.
`timescale 1ns / 1ps

module rlg_front #(
    parameter int INDEX_WIDTH = rlg_pkg::INDEX_WIDTH_DEF,
    localparam int NUM_WIDTH  = INDEX_WIDTH + rlg_pkg::QUOT_BITS
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           adv,
    input  logic                                           in_valid,
    input  logic [INDEX_WIDTH-1:0]                         in_index,
    input  rlg_pkg::color_cfg_t                            colors,
    input  logic [INDEX_WIDTH-1:0]                         step_count,
    output logic                                           out_valid,
    output logic [rlg_pkg::NUM_CHAN-1:0][NUM_WIDTH-1:0]    out_num,
    output logic [INDEX_WIDTH-1:0]                         out_span,
    output logic                                           out_err
);

    // stage A
    logic                   a_valid_reg;
    logic [INDEX_WIDTH-1:0] a_index_reg, a_rest_reg, a_span_reg;
    logic [INDEX_WIDTH-1:0] a_rest_next, a_span_next;
    logic                   a_err_reg, a_err_next;
    logic                   one_step;

    // stage B
    logic                                        b_valid_reg;
    logic [rlg_pkg::NUM_CHAN-1:0][NUM_WIDTH-1:0] b_num_reg, b_num_next;
    logic [INDEX_WIDTH-1:0]                      b_span_reg;
    logic                                        b_err_reg;

    // A count of one uses span 1 and weight 1 on the start color, so the
    // divider passes the start level through unchanged.
    always_comb begin
        one_step    = (step_count <= INDEX_WIDTH'(1));
        a_err_next  = (in_index >= step_count);
        a_span_next = one_step ? INDEX_WIDTH'(1) : step_count - INDEX_WIDTH'(1);
        a_rest_next = one_step ? INDEX_WIDTH'(1) : step_count + ~in_index;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_index_reg <= in_index;
            a_rest_reg  <= a_rest_next;
            a_span_reg  <= a_span_next;
            a_err_reg   <= a_err_next;
        end
    end

    // end * i + start * (span - i); below 1024 * span whenever the index is in range
    always_comb begin
        for (int ch = 0; ch < rlg_pkg::NUM_CHAN; ch++) begin
            b_num_next[ch] = NUM_WIDTH'(colors.end_lvl[ch]) * NUM_WIDTH'(a_index_reg)
                           + NUM_WIDTH'(colors.start_lvl[ch]) * NUM_WIDTH'(a_rest_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_num_reg  <= b_num_next;
            b_span_reg <= a_span_reg;
            b_err_reg  <= a_err_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_num   = b_num_reg;
    assign out_span  = b_span_reg;
    assign out_err   = b_err_reg;

endmodule

FILE: src/rlg_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, three color lanes sharing a divisor.
// Depends on rlg_pkg.
`timescale 1ns / 1ps

module rlg_div_pipe #(
    parameter int INDEX_WIDTH = rlg_pkg::INDEX_WIDTH_DEF,
    localparam int NUM_WIDTH  = INDEX_WIDTH + rlg_pkg::QUOT_BITS
) (
    input  logic                                                 aclk,
    input  logic                                                 aresetn,
    input  logic                                                 adv,
    input  logic                                                 in_valid,
    input  logic [rlg_pkg::NUM_CHAN-1:0][NUM_WIDTH-1:0]          in_num,
    input  logic [INDEX_WIDTH-1:0]                               in_span,
    input  logic                                                 in_err,
    output logic                                                 out_valid,
    output logic [rlg_pkg::NUM_CHAN-1:0][rlg_pkg::QUOT_BITS-1:0] out_quot,
    output logic                                                 out_err
);

    localparam int QB = rlg_pkg::QUOT_BITS;
    localparam int NC = rlg_pkg::NUM_CHAN;

    logic [QB-1:0]                 vld_reg;
    logic [QB-1:0]                 err_reg;
    logic [NC-1:0][QB-1:0]         quot_reg [QB];
    // remainder and divisor are not needed past the last stage
    logic [NC-1:0][NUM_WIDTH-1:0]  rem_reg  [QB-1];
    logic [INDEX_WIDTH-1:0]        span_reg [QB-1];

    for (genvar j = 0; j < QB; j++) begin : g_stage
        localparam int K = QB - 1 - j;

        logic [NC-1:0][NUM_WIDTH-1:0] rem_in;
        logic [NC-1:0][QB-1:0]        quot_in, quot_out;
        logic [INDEX_WIDTH-1:0]       span_in;
        logic                         err_in, vld_in;
        logic [NUM_WIDTH-1:0]         dsub;
        logic [NC-1:0][NUM_WIDTH:0]   trial;
        logic [NC-1:0]                take;

        if (j == 0) begin : g_first
            assign rem_in  = in_num;
            assign quot_in = '0;
            assign span_in = in_span;
            assign err_in  = in_err;
            assign vld_in  = in_valid;
        end else begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign quot_in = quot_reg[j-1];
            assign span_in = span_reg[j-1];
            assign err_in  = err_reg[j-1];
            assign vld_in  = vld_reg[j-1];
        end

        always_comb begin
            dsub     = NUM_WIDTH'(span_in) << K;
            quot_out = quot_in;
            for (int ch = 0; ch < NC; ch++) begin
                trial[ch]       = {1'b0, rem_in[ch]} - {1'b0, dsub};
                take[ch]        = ~trial[ch][NUM_WIDTH];
                quot_out[ch][K] = take[ch];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[j] <= 1'b0;
            end else if (adv) begin
                vld_reg[j] <= vld_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                quot_reg[j] <= quot_out;
                err_reg[j]  <= err_in;
            end
        end

        if (j < QB - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (adv) begin
                    for (int ch = 0; ch < NC; ch++) begin
                        rem_reg[j][ch] <= take[ch] ? trial[ch][NUM_WIDTH-1:0] : rem_in[ch];
                    end
                    span_reg[j] <= span_in;
                end
            end
        end
    end

    assign out_valid = vld_reg[QB-1];
    assign out_quot  = quot_reg[QB-1];
    assign out_err   = err_reg[QB-1];

endmodule

FILE: src/rlg_checker.sv
// Port-level checks for the RGB gradient block, attached to the top level by bind.
// Depends on rlg_pkg and rgb_linear_gradient_step.
`timescale 1ns / 1ps

module rlg_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [rlg_pkg::LEVEL_WIDTH-1:0] m_red,
    input logic [rlg_pkg::LEVEL_WIDTH-1:0] m_green,
    input logic [rlg_pkg::LEVEL_WIDTH-1:0] m_blue,
    input logic                            m_index_error
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_red) && $stable(m_green)
                                && $stable(m_blue) && $stable(m_index_error))
        else $error("stalled result item changed");

    // input side never blocked while the output can move
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("s_ready low with output free");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_index_error |-> m_red == '0 && m_green == '0 && m_blue == '0)
        else $error("error item with nonzero color");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_red <= rlg_pkg::LEVEL_WIDTH'(rlg_pkg::LEVEL_MAX)
                    && m_green <= rlg_pkg::LEVEL_WIDTH'(rlg_pkg::LEVEL_MAX)
                    && m_blue <= rlg_pkg::LEVEL_WIDTH'(rlg_pkg::LEVEL_MAX))
        else $error("color level above full scale");

endmodule

bind rgb_linear_gradient_step rlg_checker u_rlg_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_red         (m_red),
    .m_green       (m_green),
    .m_blue        (m_blue),
    .m_index_error (m_index_error)
);

FILE: tb/tb_top.sv
// Self-checking testbench for rgb_linear_gradient_step: directed and random step indexes.
// Depends on rlg_pkg and the block's RTL; an in-bench color predictor checks every result item.
`timescale 1ns / 1ps

module tb_top;
    import rlg_pkg::*;

    localparam int IDX_W          = INDEX_WIDTH_DEF;
    localparam int PIPE_LATENCY   = 13;    // input accept to m_valid
    // Longest quiet stretch of a correct run is the receiver hold-off or a
    // drain pause; a 63% sender gap or receiver stall rarely lasts as long.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_LEN   = 150;
    localparam int ITEMS_PER_SET  = 70;
    localparam int SETS_PER_PHASE = 5;
    // No register sits at this index: writes to it must be dropped.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;

    typedef longint unsigned u64_t;

    typedef struct packed {
        level_t red;
        level_t green;
        level_t blue;
        logic   index_error;
    } gradient_color_t;

    logic                       aclk          = 1'b0;
    logic                       aresetn       = 1'b0;
    logic                       cfg_valid     = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index     = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data      = '0;
    logic                       s_valid       = 1'b0;
    logic                       s_ready;
    logic [STEP_WIDTH-1:0]      s_step_index  = '0;
    logic                       m_valid;
    logic                       m_ready       = 1'b0;
    logic [LEVEL_WIDTH-1:0]     m_red;
    logic [LEVEL_WIDTH-1:0]     m_green;
    logic [LEVEL_WIDTH-1:0]     m_blue;
    logic                       m_index_error;

    // Shadow of the block's registers, at their reset values.
    logic [CHAN_WIDTH-1:0] start_chan [NUM_CHAN] = '{8'd0, 8'd0, 8'd0};
    logic [CHAN_WIDTH-1:0] end_chan   [NUM_CHAN] = '{8'd255, 8'd255, 8'd255};
    logic [IDX_W-1:0]      step_cnt              = IDX_W'(COUNT_RESET);

    gradient_color_t pending_colors [$];   // predicted colors, oldest first
    gradient_color_t want_color;

    int fail_count       = 0;
    int idle_cycles      = 0;
    int sender_idle_pct  = 0;
    int recv_stall_pct   = 0;
    int hold_cycles      = 0;
    int hold_req         = 0;   // bumped by a test to ask for a hold-off
    int hold_seen        = 0;   // last request taken up by the receiver

    rgb_linear_gradient_step #(
        .INDEX_WIDTH (IDX_W)
    ) u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_step_index  (s_step_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_red         (m_red),
        .m_green       (m_green),
        .m_blue        (m_blue),
        .m_index_error (m_index_error)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Color predictor
    // ------------------------------------------------------------------

    // 8-bit channel to the 0..1000 scale, round to nearest.
    function automatic int unsigned to_level(logic [CHAN_WIDTH-1:0] chan);
        return (2000 * int'(chan) + 255) / 510;
    endfunction

    function automatic level_t blend_level(logic [CHAN_WIDTH-1:0] s8, logic [CHAN_WIDTH-1:0] e8,
                                           int unsigned idx, int unsigned cnt);
        int unsigned s_lvl;
        int unsigned e_lvl;
        int unsigned span;
        u64_t        num;
        s_lvl = to_level(s8);
        e_lvl = to_level(e8);
        // single step: start color, no division
        if (cnt <= 1) begin
            return level_t'(s_lvl);
        end
        span = cnt - 1;
        num  = u64_t'(e_lvl) * idx + u64_t'(s_lvl) * (span - idx);
        return level_t'(num / span);
    endfunction

    function automatic gradient_color_t predict_color(logic [STEP_WIDTH-1:0] step);
        gradient_color_t  c;
        logic [IDX_W-1:0] idx;
        c   = '0;
        idx = step[IDX_W-1:0];
        // out of range (a zero count lands here for every index): flag, black
        if (idx >= step_cnt) begin
            c.index_error = 1'b1;
            return c;
        end
        c.red   = blend_level(start_chan[CHAN_RED], end_chan[CHAN_RED], idx, step_cnt);
        c.green = blend_level(start_chan[CHAN_GREEN], end_chan[CHAN_GREEN], idx, step_cnt);
        c.blue  = blend_level(start_chan[CHAN_BLUE], end_chan[CHAN_BLUE], idx, step_cnt);
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Result checking, receiver stalls, watchdog
    // ------------------------------------------------------------------

    task automatic report_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_colors.size() == 0) begin
                $error("result item with no prediction waiting");
                fail_count++;
            end else begin
                want_color = pending_colors.pop_front();
                report_field("red", want_color.red, m_red);
                report_field("green", want_color.green, m_green);
                report_field("blue", want_color.blue, m_blue);
                report_field("index_error", want_color.index_error, m_index_error);
            end
        end
    end

    // Receiver: a requested hold-off wins, otherwise random stalls.
    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            m_ready     <= 1'b0;
            hold_cycles <= HOLD_OFF_LEN - 1;
        end else if (hold_cycles > 0) begin
            m_ready     <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Counts cycles in which no channel moves an item.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Drivers (all entered and left at a falling edge)
    // ------------------------------------------------------------------

    // Register write; cfg_valid stays high for back-to-back writes.
    task automatic write_cfg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_START_RED:   start_chan[CHAN_RED]   = data[CHAN_WIDTH-1:0];
            REG_START_GREEN: start_chan[CHAN_GREEN] = data[CHAN_WIDTH-1:0];
            REG_START_BLUE:  start_chan[CHAN_BLUE]  = data[CHAN_WIDTH-1:0];
            REG_END_RED:     end_chan[CHAN_RED]     = data[CHAN_WIDTH-1:0];
            REG_END_GREEN:   end_chan[CHAN_GREEN]   = data[CHAN_WIDTH-1:0];
            REG_END_BLUE:    end_chan[CHAN_BLUE]    = data[CHAN_WIDTH-1:0];
            REG_STEP_COUNT:  step_cnt               = data[IDX_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
    endtask

    task automatic cfg_release();
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Upper data bits are passed through so wide values get exercised.
    task automatic set_gradient(logic [15:0] sr, logic [15:0] sg, logic [15:0] sb,
                                logic [15:0] er, logic [15:0] eg, logic [15:0] eb,
                                logic [15:0] cnt);
        write_cfg(REG_START_RED, sr);
        write_cfg(REG_START_GREEN, sg);
        write_cfg(REG_START_BLUE, sb);
        write_cfg(REG_END_RED, er);
        write_cfg(REG_END_GREEN, eg);
        write_cfg(REG_END_BLUE, eb);
        write_cfg(REG_STEP_COUNT, cnt);
        cfg_release();
    endtask

    // One step index item. Valid stays high into the next item unless a gap is drawn.
    task automatic send_step(logic [STEP_WIDTH-1:0] idx);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_step_index <= idx;
        do @(posedge aclk); while (!s_ready);
        pending_colors.push_back(predict_color(idx));
        @(negedge aclk);
    endtask

    // Quiet the sender, wait out every prediction, then let the pipe empty.
    task automatic wait_drain();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_colors.size() != 0) @(negedge aclk);
        repeat (PIPE_LATENCY + 4) @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_chan();
        logic [7:0] lo;
        case ($urandom_range(4))
            0:       lo = 8'd0;
            1:       lo = 8'd255;
            default: lo = 8'($urandom_range(255));
        endcase
        return {8'($urandom_range(255)), lo};
    endfunction

    // Mostly in range; a few just past the end, a few anywhere.
    function automatic logic [15:0] pick_step_index(logic [15:0] cnt);
        int r;
        r = $urandom_range(99);
        if (cnt != 0 && r < 85) return 16'($urandom_range(cnt - 1, 0));
        if (r < 93) return 16'(cnt + $urandom_range(3));
        return 16'($urandom_range(16'hFFFF));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset config: black to white over two steps.
    task automatic test_reset_defaults();
        send_step(16'd0);
        send_step(16'd1);
        send_step(16'd2);
        send_step(16'hFFFF);
        wait_drain();
    endtask

    // Largest count, both ends, just past the end; junk in the upper data byte.
    task automatic test_endpoints();
        set_gradient(16'h00FF, 16'hFF00, 16'hAB80, 16'h1200, 16'h00FF, 16'h0001, 16'hFFFF);
        send_step(16'd0);
        send_step(16'hFFFE);
        send_step(16'hFFFF);
        send_step(16'h7FFF);
        send_step(16'd1);
        wait_drain();
    endtask

    // Count of one: no division. The unused register index must not disturb it.
    task automatic test_single_step();
        set_gradient(16'd77, 16'd200, 16'd3, 16'd255, 16'd0, 16'd128, 16'd1);
        write_cfg(REG_UNUSED, 16'h0005);
        cfg_release();
        send_step(16'd0);
        send_step(16'd1);
        send_step(16'hFFFF);
        wait_drain();
    endtask

    // Zero count: everything out of range.
    task automatic test_zero_count();
        set_gradient(16'd255, 16'd255, 16'd255, 16'd0, 16'd0, 16'd0, 16'd0);
        send_step(16'd0);
        send_step(16'd1);
        send_step(16'hFFFF);
        wait_drain();
    endtask

    // Interior steps: an exact midpoint, then steps where the division truncates.
    task automatic test_midpoints();
        set_gradient(16'd0, 16'd0, 16'd0, 16'd255, 16'd255, 16'd255, 16'd3);
        send_step(16'd1);
        wait_drain();
        set_gradient(16'd0, 16'd1, 16'd254, 16'd255, 16'd254, 16'd1, 16'd4);
        send_step(16'd1);
        send_step(16'd2);
        wait_drain();
    endtask

    task automatic test_random_phases();
        logic [15:0] cnt;
        int          sweep;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin sender_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            for (int k = 0; k < SETS_PER_PHASE; k++) begin
                // rotate through count classes so each is hit in several phases
                case ((phase * SETS_PER_PHASE + k) % 7)
                    0:       cnt = 16'd1;
                    1:       cnt = 16'd2;
                    2:       cnt = 16'($urandom_range(20, 3));
                    3:       cnt = 16'($urandom_range(1000, 21));
                    4:       cnt = 16'hFFFF;
                    5:       cnt = 16'($urandom_range(16'hFFFF));
                    default: cnt = 16'd0;
                endcase
                set_gradient(rand_chan(), rand_chan(), rand_chan(),
                             rand_chan(), rand_chan(), rand_chan(), cnt);
                if ($urandom_range(3) == 0) begin
                    write_cfg(REG_UNUSED, 16'($urandom_range(16'hFFFF)));
                    cfg_release();
                end
                // short palettes are often walked in order, like a real palette fill
                sweep = (cnt != 0 && cnt <= 100 && $urandom_range(1) == 1);
                for (int n = 0; n < ITEMS_PER_SET; n++) begin
                    if (sweep && $urandom_range(9) != 0) send_step(16'(n % cnt));
                    else send_step(pick_step_index(cnt));
                end
                wait_drain();
            end
        end
    endtask

    // Receiver holds off long enough for the pipe to fill and s_ready to drop.
    task automatic test_backpressure();
        set_gradient(rand_chan(), rand_chan(), rand_chan(),
                     rand_chan(), rand_chan(), rand_chan(), 16'd200);
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        @(posedge aclk);
        hold_req <= hold_req + 1;
        @(negedge aclk);
        for (int n = 0; n < 60; n++) send_step(pick_step_index(16'd200));
        wait_drain();
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_endpoints();
        test_single_step();
        test_zero_count();
        test_midpoints();
        test_random_phases();
        test_backpressure();

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
